// ===== rtl/vcf_genotype_recoder_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the genotype recoder RTL.
// Each macro samples on clk and is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef VCF_GENOTYPE_RECODER_CORE_ASSERT_SVH
`define VCF_GENOTYPE_RECODER_CORE_ASSERT_SVH

// Same-cycle implication
`define VGR_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("genotype recoder check failed");

// Next-cycle implication
`define VGR_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("genotype recoder check failed");

`endif

// ===== rtl/vgr_pkg.sv =====
// ---------------------------------------------------------------------------
// vgr_pkg
// Types and constants shared by the genotype recoder front, queue and back.
// ---------------------------------------------------------------------------
package vgr_pkg;

    // Field widths
    localparam int COL_W    = 16;
    localparam int COLS_W   = 17;
    localparam int ROW_W    = 24;
    localparam int GENO_W   = 2;
    localparam int STATUS_W = 2;

    // ASCII codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Result kinds
    localparam logic KIND_GENO   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Row status codes
    localparam logic [STATUS_W-1:0] STATUS_KEPT     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REMOVED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BADCOUNT = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_TOOMANY  = 2'd3;

    // Genotype codes
    localparam logic [GENO_W-1:0] GENO_ZERO    = 2'd0;
    localparam logic [GENO_W-1:0] GENO_MISSING = 2'd1;
    localparam logic [GENO_W-1:0] GENO_MAX     = 2'd2;

    // Op queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified byte: up to one genotype beat and one status beat
    typedef struct packed {
        logic                geno_valid;
        logic [GENO_W-1:0]   geno_code;
        logic [COL_W-1:0]    column;
        logic [ROW_W-1:0]    row;
        logic                status_valid;
        logic [STATUS_W-1:0] status;
    } vgr_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } vgr_q_status_t;

endpackage

// ===== rtl/vgr_front.sv =====
// ---------------------------------------------------------------------------
// vgr_front
// Byte classifier: tracks columns and alleles of the current line and turns
// each accepted byte into an op for the back end.
// ---------------------------------------------------------------------------
module vgr_front #(
    parameter int MAX_SAMPLES  = 65535,
    parameter int SKIP_COLUMNS = 9
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [7:0]                 text_byte,
    input  logic                       line_end,
    input  logic [vgr_pkg::COL_W-1:0]  expected_samples,
    output logic                       push,
    output vgr_pkg::vgr_op_t           op
);
    import vgr_pkg::*;

    localparam int TAB_W = $clog2(SKIP_COLUMNS + 1);
    localparam logic [TAB_W-1:0] SKIP_CNT = TAB_W'(SKIP_COLUMNS);
    localparam int COL_MAX = (1 << COL_W) - 1;
    localparam int CAP = (MAX_SAMPLES > COL_MAX) ? COL_MAX : MAX_SAMPLES;
    localparam logic [COL_W-1:0] LIMIT_CAP = COL_W'(CAP);

    logic [7:0]          prev_reg, prev_next;
    logic [TAB_W-1:0]    tabs_reg, tabs_next;
    logic [GENO_W-1:0]   sum_reg, sum_next;
    logic                missing_reg, missing_next;
    logic                removed_reg, removed_next;
    logic                overflow_reg, overflow_next;
    logic [COLS_W-1:0]   cols_reg, cols_next;
    logic [ROW_W-1:0]    rows_reg, rows_next;

    logic [COL_W-1:0]    limit;
    logic [COLS_W-1:0]   limit_ext;
    logic                after_tab, after_sep, open, high, emit, geno_valid;
    logic [GENO_W-1:0]   geno_code;
    logic [STATUS_W-1:0] status;

    // Effective sample limit
    assign limit     = (expected_samples > LIMIT_CAP) ? LIMIT_CAP : expected_samples;
    assign limit_ext = {{(COLS_W - COL_W){1'b0}}, limit};

    // Classify the byte and work out the next line state
    always_comb
    begin
        prev_next     = text_byte;
        tabs_next     = tabs_reg;
        sum_next      = sum_reg;
        missing_next  = missing_reg;
        removed_next  = removed_reg;
        overflow_next = overflow_reg;
        cols_next     = cols_reg;
        rows_next     = rows_reg;
        emit          = 1'b0;
        geno_valid    = 1'b0;
        geno_code     = GENO_ZERO;
        status        = STATUS_KEPT;
        after_tab     = (prev_reg == CH_TAB);
        after_sep     = (prev_reg == CH_SLASH) || (prev_reg == CH_PIPE);
        open          = !missing_reg && !removed_reg;
        high          = (text_byte >= CH_TWO) && (text_byte <= CH_NINE);

        if (tabs_reg < SKIP_CNT)
        begin
            if (text_byte == CH_TAB)
                tabs_next = tabs_reg + 1'b1;
        end
        else
        begin
            if (after_tab && text_byte == CH_ZERO)
            begin
                sum_next     = GENO_ZERO;
                missing_next = 1'b0;
            end
            else if (after_tab && text_byte == CH_ONE)
            begin
                sum_next     = GENO_MISSING;
                missing_next = 1'b0;
            end
            else if (after_tab && high)
                removed_next = 1'b1;
            else if (after_tab && text_byte == CH_DOT)
            begin
                missing_next = 1'b1;
                emit         = 1'b1;
            end
            else if (open && after_sep && text_byte == CH_ZERO)
                emit = 1'b1;
            else if (open && after_sep && text_byte == CH_ONE)
            begin
                if (sum_reg < GENO_MAX)
                    sum_next = sum_reg + 1'b1;
                emit = 1'b1;
            end
            else if (open && after_sep && high)
                removed_next = 1'b1;
            else if (open && after_sep && text_byte == CH_DOT)
            begin
                missing_next = 1'b1;
                emit         = 1'b1;
            end

            // Drop genotypes of a removed or overflowed row
            if (removed_next || overflow_reg)
                emit = 1'b0;

            if (emit)
            begin
                if (cols_reg >= limit_ext)
                    overflow_next = 1'b1;
                else
                begin
                    geno_valid = 1'b1;
                    geno_code  = missing_next ? GENO_MISSING : sum_next;
                    cols_next  = cols_reg + 1'b1;
                end
            end
        end

        // Close the row at line end
        if (line_end)
        begin
            if (overflow_next)
                status = STATUS_TOOMANY;
            else if (removed_next)
                status = STATUS_REMOVED;
            else if (cols_next != limit_ext)
                status = STATUS_BADCOUNT;
            else
                status = STATUS_KEPT;
            tabs_next     = '0;
            removed_next  = 1'b0;
            overflow_next = 1'b0;
            cols_next     = '0;
            prev_next     = 8'h00;
            rows_next     = rows_reg + 1'b1;
        end
    end

    // Build the op; it carries the genotype count before this byte, which the back updates for a status beat
    always_comb
    begin
        op.geno_valid   = geno_valid;
        op.geno_code    = geno_code;
        op.column       = cols_reg[COL_W-1:0];
        op.row          = rows_reg;
        op.status_valid = line_end;
        op.status       = status;
    end

    assign push = accept && (geno_valid || line_end);

    // Advance line state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= '0;
            tabs_reg     <= '0;
            sum_reg      <= '0;
            missing_reg  <= 1'b0;
            removed_reg  <= 1'b0;
            overflow_reg <= 1'b0;
            cols_reg     <= '0;
            rows_reg     <= '0;
        end
        else if (accept)
        begin
            prev_reg     <= prev_next;
            tabs_reg     <= tabs_next;
            sum_reg      <= sum_next;
            missing_reg  <= missing_next;
            removed_reg  <= removed_next;
            overflow_reg <= overflow_next;
            cols_reg     <= cols_next;
            rows_reg     <= rows_next;
        end
    end

`include "vcf_genotype_recoder_core_assert.svh"

    // A genotype never reaches past the sample limit
    `VGR_ASSERT_IMP(a_geno_below_limit, push && op.geno_valid, {1'b0, op.column} < limit_ext)
    // The genotype count of a row never exceeds the limit
    `VGR_ASSERT_IMP(a_cols_bounded, 1'b1, cols_reg <= limit_ext || expected_samples != limit)

endmodule

// ===== rtl/vgr_queue.sv =====
// ---------------------------------------------------------------------------
// vgr_queue
// Small op queue that decouples the byte classifier from the beat emitter.
// ---------------------------------------------------------------------------
module vgr_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  vgr_pkg::vgr_op_t        push_op,
    input  logic                    pop,
    output vgr_pkg::vgr_op_t        head_op,
    output vgr_pkg::vgr_q_status_t  q_status
);
    import vgr_pkg::*;

    localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QUEUE_DEPTH);

    vgr_op_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign q_status.full  = (count_reg == DEPTH_CNT);
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_op        = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store ops
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

`include "vcf_genotype_recoder_core_assert.svh"

    // Occupancy stays within the storage
    `VGR_ASSERT_IMP(a_count_bounded, 1'b1, count_reg <= DEPTH_CNT)
    // The classifier never pushes into a full queue
    `VGR_ASSERT_IMP(a_no_push_full, push, !q_status.full)

endmodule

// ===== rtl/vgr_back.sv =====
// ---------------------------------------------------------------------------
// vgr_back
// Beat emitter: expands each queued op into its genotype and status beats
// and holds them in the output register.
// ---------------------------------------------------------------------------
module vgr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vgr_pkg::vgr_op_t              head_op,
    input  vgr_pkg::vgr_q_status_t        q_status,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          kind,
    output logic [vgr_pkg::GENO_W-1:0]    genotype,
    output logic [vgr_pkg::COL_W-1:0]     column,
    output logic [vgr_pkg::ROW_W-1:0]     row_index,
    output logic [vgr_pkg::STATUS_W-1:0]  row_status,
    output logic                          last
);
    import vgr_pkg::*;

    logic                 valid_reg, valid_next;
    logic                 pending_reg, pending_next;
    logic                 kind_reg, kind_next;
    logic [GENO_W-1:0]    geno_reg, geno_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 last_reg, last_next;
    logic                 can_load, send_geno;

    assign can_load  = !valid_reg || !out_stall;
    assign send_geno = head_op.geno_valid && !pending_reg;
    assign pop       = can_load && !q_status.empty && (!send_geno || !head_op.status_valid);

    // Pick the next beat from the head op
    always_comb
    begin
        valid_next   = valid_reg;
        pending_next = pending_reg;
        kind_next    = kind_reg;
        geno_next    = geno_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        if (can_load)
        begin
            valid_next = !q_status.empty;
            if (!q_status.empty)
            begin
                row_next = head_op.row;
                if (send_geno)
                begin
                    kind_next    = KIND_GENO;
                    geno_next    = head_op.geno_code;
                    col_next     = head_op.column;
                    status_next  = STATUS_KEPT;
                    last_next    = !head_op.status_valid;
                    pending_next = head_op.status_valid;
                end
                else
                begin
                    kind_next    = KIND_STATUS;
                    geno_next    = GENO_ZERO;
                    col_next     = head_op.geno_valid ? head_op.column + 1'b1 : head_op.column;
                    status_next  = head_op.status;
                    last_next    = 1'b1;
                    pending_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            pending_reg <= pending_next;
        end
    end

    // Hold beat payload
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        geno_reg   <= geno_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign out_valid  = valid_reg;
    assign kind       = kind_reg;
    assign genotype   = geno_reg;
    assign column     = col_reg;
    assign row_index  = row_reg;
    assign row_status = status_reg;
    assign last       = last_reg;

`include "vcf_genotype_recoder_core_assert.svh"

    // While a status beat is owed, the register holds its genotype beat
    `VGR_ASSERT_IMP(a_pending_geno, pending_reg, valid_reg && kind_reg == KIND_GENO)
    // A genotype beat that is not last is always followed by its status beat
    `VGR_ASSERT_IMP(a_geno_not_last, valid_reg && kind_reg == KIND_GENO && !last_reg, pending_reg)

endmodule

// ===== rtl/vcf_genotype_recoder_core.sv =====
// ---------------------------------------------------------------------------
// vcf_genotype_recoder_core
// Variant line parser that recodes diploid sample calls into allele counts.
// ---------------------------------------------------------------------------
// Takes one text byte per clock while the queue has room. The front classifies
// each byte combinationally and pushes at most one op into a four-entry queue;
// the back turns each op into one or two result beats and issues one beat per
// clock from its output register while out_stall is low. A byte is taken every
// cycle while the queue has room, so the sustained rate is one byte per clock;
// only a line-end byte that also closes a genotype yields two beats; the queue
// absorbs that extra beat. Each accepted byte's op passes a queue entry and the
// output register on its way out. The user must write expected_samples through
// cfg_we and cfg_wdata while the block is idle; the block does not enforce it.
module vcf_genotype_recoder_core #(
    parameter int MAX_SAMPLES  = 65535,
    parameter int SKIP_COLUMNS = 9
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vgr_pkg::COL_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    text_byte,
    input  logic                          line_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          kind,
    output logic [vgr_pkg::GENO_W-1:0]    genotype,
    output logic [vgr_pkg::COL_W-1:0]     column,
    output logic [vgr_pkg::ROW_W-1:0]     row_index,
    output logic [vgr_pkg::STATUS_W-1:0]  row_status,
    output logic                          last
);
    import vgr_pkg::*;

    logic [COL_W-1:0] samples_reg;
    logic             accept, push, pop;
    vgr_op_t          push_op, head_op;
    vgr_q_status_t    q_status;

    // Hold the sample count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            samples_reg <= COL_W'(1);
        else if (cfg_we)
            samples_reg <= cfg_wdata;
    end

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    vgr_front #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SKIP_COLUMNS (SKIP_COLUMNS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .text_byte        (text_byte),
        .line_end         (line_end),
        .expected_samples (samples_reg),
        .push             (push),
        .op               (push_op)
    );

    vgr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .pop      (pop),
        .head_op  (head_op),
        .q_status (q_status)
    );

    vgr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_op    (head_op),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .genotype   (genotype),
        .column     (column),
        .row_index  (row_index),
        .row_status (row_status),
        .last       (last)
    );

endmodule

// ===== sim/tb_vcf_genotype_recoder_core.sv =====
// ---------------------------------------------------------------------------
// tb_vcf_genotype_recoder_core
// Self-checking bench for the variant line genotype recoder.
// ---------------------------------------------------------------------------
// Feeds whole data lines one byte per beat and predicts every genotype and
// row status beat in step with the input. Covers short lines, missing and
// multiallelic calls, third alleles, overflow past the sample count and raw
// noise. Runs several phases with different sample counts and different
// amounts of sender idling and receiver stall, including one long hold-off.
// ---------------------------------------------------------------------------
module tb_vcf_genotype_recoder_core;
    import vgr_pkg::*;

    localparam int MAX_SAMPLES   = 65535;
    localparam int SKIP_COLUMNS  = 9;
    localparam int PHASES        = 9;
    localparam int PHASE_BYTES   = 56;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 20;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_FILL  = 8'h41;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_HOLD} idle_mode_t;

    typedef struct packed {
        logic [7:0] text;
        logic       eol;
    } text_beat_t;

    typedef struct packed {
        logic                kind;
        logic [GENO_W-1:0]   geno;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic [STATUS_W-1:0] status;
        logic                last;
    } result_beat_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [COL_W-1:0]    cfg_wdata = '0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [7:0]          text_byte = '0;
    logic                line_end  = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                kind;
    logic [GENO_W-1:0]   genotype;
    logic [COL_W-1:0]    column;
    logic [ROW_W-1:0]    row_index;
    logic [STATUS_W-1:0] row_status;
    logic                last;

    vcf_genotype_recoder_core #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SKIP_COLUMNS (SKIP_COLUMNS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .line_end   (line_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .genotype   (genotype),
        .column     (column),
        .row_index  (row_index),
        .row_status (row_status),
        .last       (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    text_beat_t   pending_text_q[$];
    result_beat_t expected_beats_q[$];
    logic [7:0]   line_text[$];

    idle_mode_t   idle_mode = IDLE_NONE;
    logic         text_taken = 1'b0;
    int           hold_count = 0;
    int           error_count = 0;
    int           phase_bytes;
    int unsigned  phase_samples;

    int unsigned  phase_cfg [PHASES] = '{1, 3, 2, 4, 65535, 0, 2, 1, 5};
    idle_mode_t   phase_idle [PHASES] = '{IDLE_NONE, IDLE_NONE, IDLE_SEND, IDLE_RECV,
                                          IDLE_BOTH, IDLE_SEND, IDLE_HOLD, IDLE_BOTH,
                                          IDLE_RECV};

    // Recoder state mirrored by the predictor
    logic [7:0]          gt_prev;
    logic [3:0]          gt_tabs;
    logic [1:0]          gt_sum;
    logic                gt_missing;
    logic                gt_removed;
    logic                gt_overflow;
    logic [COLS_W-1:0]   gt_cols;
    logic [ROW_W-1:0]    gt_rows;
    logic [COL_W-1:0]    gt_samples;

    function automatic result_beat_t row_beat(input logic k, input logic [GENO_W-1:0] g,
                                              input logic [STATUS_W-1:0] s);
        result_beat_t b;
        b.kind   = k;
        b.geno   = g;
        b.col    = gt_cols[COL_W-1:0];
        b.row    = gt_rows;
        b.status = s;
        b.last   = 1'b0;
        return b;
    endfunction

    // Advance the recoder state by one byte and queue the beats it yields
    task automatic recode_byte(input logic [7:0] c, input logic eol);
        logic [COLS_W-1:0]   limit;
        logic                emit;
        logic                after_tab;
        logic                after_sep;
        logic                open_call;
        logic                high_digit;
        logic [STATUS_W-1:0] st;
        result_beat_t        beats [2];
        int                  n;
        limit = (gt_samples > MAX_SAMPLES) ? COLS_W'(MAX_SAMPLES) : COLS_W'(gt_samples);
        n     = 0;
        emit  = 1'b0;
        if (gt_tabs < SKIP_COLUMNS) begin
            if (c == CH_TAB)
                gt_tabs = gt_tabs + 4'd1;
        end
        else begin
            after_tab  = (gt_prev == CH_TAB);
            after_sep  = (gt_prev == CH_SLASH) || (gt_prev == CH_PIPE);
            open_call  = !gt_missing && !gt_removed;
            high_digit = (c >= CH_TWO) && (c <= CH_NINE);
            if (after_tab && c == CH_ZERO) begin
                gt_sum = 2'd0;
                gt_missing = 1'b0;
            end
            else if (after_tab && c == CH_ONE) begin
                gt_sum = 2'd1;
                gt_missing = 1'b0;
            end
            else if (after_tab && high_digit)
                gt_removed = 1'b1;
            else if (after_tab && c == CH_DOT) begin
                gt_missing = 1'b1;
                emit = 1'b1;
            end
            else if (open_call && after_sep && c == CH_ZERO)
                emit = 1'b1;
            else if (open_call && after_sep && c == CH_ONE) begin
                if (gt_sum < 2'd2)
                    gt_sum = gt_sum + 2'd1;
                emit = 1'b1;
            end
            else if (open_call && after_sep && high_digit)
                gt_removed = 1'b1;
            else if (open_call && after_sep && c == CH_DOT) begin
                gt_missing = 1'b1;
                emit = 1'b1;
            end
            if (gt_removed || gt_overflow)
                emit = 1'b0;
            if (emit) begin
                if (gt_cols >= limit)
                    gt_overflow = 1'b1;
                else begin
                    beats[n] = row_beat(KIND_GENO, gt_missing ? GENO_MISSING : gt_sum,
                                        STATUS_KEPT);
                    n++;
                    gt_cols = gt_cols + 1'b1;
                end
            end
        end
        gt_prev = c;
        // Close the row: report status and clear the per-row state
        if (eol) begin
            if (gt_overflow)
                st = STATUS_TOOMANY;
            else if (gt_removed)
                st = STATUS_REMOVED;
            else if (gt_cols != limit)
                st = STATUS_BADCOUNT;
            else
                st = STATUS_KEPT;
            beats[n] = row_beat(KIND_STATUS, GENO_ZERO, st);
            n++;
            gt_tabs     = '0;
            gt_removed  = 1'b0;
            gt_overflow = 1'b0;
            gt_cols     = '0;
            gt_prev     = '0;
            gt_rows     = gt_rows + 1'b1;
        end
        if (n > 0)
            beats[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_beats_q.push_back(beats[i]);
    endtask

    function automatic logic [7:0] field_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == CH_TAB) ? CH_FILL : b;
    endfunction

    function automatic logic [7:0] allele_char();
        return CH_ZERO + 8'($urandom_range(0, 1));
    endfunction

    task automatic put_skip_columns(input int tabs, input int max_fill);
        int fill;
        for (int i = 0; i < tabs; i++) begin
            fill = $urandom_range(0, max_fill);
            for (int j = 0; j < fill; j++)
                line_text.push_back(field_byte());
            line_text.push_back(CH_TAB);
        end
    endtask

    // Append one sample column: mostly diploid calls, some odd shapes
    task automatic put_call();
        int         r;
        int         sfx;
        logic [7:0] sep;
        logic [7:0] a;
        logic [7:0] b;
        r   = $urandom_range(0, 99);
        sep = $urandom_range(0, 1) ? CH_SLASH : CH_PIPE;
        a   = allele_char();
        b   = allele_char();
        if (r < 62) begin
            line_text.push_back(a); line_text.push_back(sep); line_text.push_back(b);
        end
        else if (r < 68) begin
            line_text.push_back(CH_DOT); line_text.push_back(sep); line_text.push_back(b);
        end
        else if (r < 73) begin
            line_text.push_back(a); line_text.push_back(sep); line_text.push_back(CH_DOT);
        end
        else if (r < 77) begin
            line_text.push_back(CH_DOT); line_text.push_back(sep);
            line_text.push_back(CH_DOT);
        end
        else if (r < 81) begin
            if ($urandom_range(0, 1))
                a = CH_TWO + 8'($urandom_range(0, 7));
            else
                b = CH_TWO + 8'($urandom_range(0, 7));
            line_text.push_back(a); line_text.push_back(sep); line_text.push_back(b);
        end
        else if (r < 86) begin
            line_text.push_back(a); line_text.push_back(sep); line_text.push_back(b);
            line_text.push_back(sep); line_text.push_back(CH_ONE);
        end
        else if (r < 91)
            line_text.push_back(a);
        else begin
            sfx = $urandom_range(1, 3);
            for (int i = 0; i < sfx; i++)
                line_text.push_back(field_byte());
        end
        // Tack on a format suffix now and then
        if ($urandom_range(0, 3) == 0) begin
            line_text.push_back(CH_COLON);
            sfx = $urandom_range(1, 2);
            for (int i = 0; i < sfx; i++)
                line_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    function automatic int pick_samples(input int unsigned lim);
        int r;
        if (lim > 6)
            return $urandom_range(0, 3);
        r = $urandom_range(0, 9);
        if (r < 6)
            return lim;
        if (r < 8)
            return (lim == 0) ? 0 : lim - 1;
        return lim + 1 + $urandom_range(0, 1);
    endfunction

    // Move the built line into the send queue, flagging its last byte
    task automatic send_line();
        text_beat_t tb;
        if (line_text.size() == 0)
            line_text.push_back(field_byte());
        foreach (line_text[i]) begin
            tb.text = line_text[i];
            tb.eol  = (i == line_text.size() - 1);
            pending_text_q.push_back(tb);
        end
        phase_bytes += line_text.size();
        line_text.delete();
    endtask

    // Build one random line: mostly well formed, some short, noisy or cut off
    task automatic put_line();
        int shape;
        int count;
        int cut;
        shape = $urandom_range(0, 99);
        if (shape < 8)
            put_skip_columns($urandom_range(0, SKIP_COLUMNS - 1), 2);
        else if (shape < 14) begin
            count = $urandom_range(1, 12);
            for (int i = 0; i < count; i++)
                line_text.push_back(8'($urandom_range(0, 255)));
        end
        else begin
            put_skip_columns(SKIP_COLUMNS, 2);
            count = pick_samples(phase_samples);
            for (int s = 0; s < count; s++) begin
                if (s > 0)
                    line_text.push_back(CH_TAB);
                put_call();
            end
            if (shape < 20 && line_text.size() > 1) begin
                cut = $urandom_range(1, line_text.size() - 1);
                while (line_text.size() > cut)
                    void'(line_text.pop_back());
            end
        end
        send_line();
    endtask

    // Wait until all beats are out, then let the pipeline settle
    task automatic drain();
        while (pending_text_q.size() != 0 || in_valid || expected_beats_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_samples(input int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= COL_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        gt_samples    = COL_W'(value);
        phase_samples = value;
    endtask

    // Offer text beats; hold a stalled beat, otherwise idle at random
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || text_taken) begin
            if (pending_text_q.size() != 0 && $urandom_range(0, 99) >=
                ((idle_mode == IDLE_SEND) ? 53 : (idle_mode == IDLE_BOTH) ? 7 : 0)) begin
                in_valid  <= 1'b1;
                text_byte <= pending_text_q[0].text;
                line_end  <= pending_text_q[0].eol;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall the result side; one long hold-off fills the block up
    always @(negedge clk)
    begin
        if (idle_mode == IDLE_HOLD && hold_count < HOLD_CYCLES) begin
            out_stall <= 1'b1;
            hold_count++;
        end
        else
            out_stall <= ($urandom_range(0, 99) <
                          ((idle_mode == IDLE_RECV) ? 53 : (idle_mode == IDLE_BOTH) ? 7 : 0));
    end

    result_beat_t got_beat;
    result_beat_t want_beat;

    // Predict on accepted text beats, check accepted result beats
    always @(posedge clk)
    begin
        text_taken <= in_valid && !in_stall;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                void'(pending_text_q.pop_front());
                recode_byte(text_byte, line_end);
            end
            if (out_valid && !out_stall) begin
                got_beat = {kind, genotype, column, row_index, row_status, last};
                if (expected_beats_q.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected beat kind=%0d geno=%0d col=%0d row=%0d st=%0d last=%0d",
                                 $time, kind, genotype, column, row_index, row_status, last);
                end
                else begin
                    want_beat = expected_beats_q.pop_front();
                    if (got_beat.kind !== want_beat.kind || got_beat.geno !== want_beat.geno ||
                        got_beat.col !== want_beat.col || got_beat.row !== want_beat.row ||
                        got_beat.status !== want_beat.status ||
                        got_beat.last !== want_beat.last) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: mismatch exp kind=%0d geno=%0d col=%0d row=%0d st=%0d last=%0d got kind=%0d geno=%0d col=%0d row=%0d st=%0d last=%0d",
                                     $time, want_beat.kind, want_beat.geno, want_beat.col,
                                     want_beat.row, want_beat.status, want_beat.last,
                                     got_beat.kind, got_beat.geno, got_beat.col,
                                     got_beat.row, got_beat.status, got_beat.last);
                    end
                end
            end
        end
    end

    // Sequence reset, directed lines and the random phases
    initial
    begin
        gt_prev     = '0;
        gt_tabs     = '0;
        gt_sum      = '0;
        gt_missing  = 1'b0;
        gt_removed  = 1'b0;
        gt_overflow = 1'b0;
        gt_cols     = '0;
        gt_rows     = '0;
        gt_samples  = COL_W'(1);
        phase_samples = 1;
        phase_bytes   = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_mode = IDLE_NONE;

        // Directed: one-byte lines with all bits set and clear, a call closed
        // on the line-end byte, and a missing first allele
        line_text.push_back(8'hFF);
        send_line();
        line_text.push_back(8'h00);
        send_line();
        put_skip_columns(SKIP_COLUMNS, 0);
        line_text.push_back(CH_ONE); line_text.push_back(CH_PIPE);
        line_text.push_back(CH_ONE);
        send_line();
        put_skip_columns(SKIP_COLUMNS, 0);
        line_text.push_back(CH_DOT); line_text.push_back(CH_SLASH);
        line_text.push_back(CH_ONE);
        send_line();

        for (int p = 1; p < PHASES; p++) begin
            drain();
            write_samples(phase_cfg[p]);
            @(posedge clk);
            idle_mode   = phase_idle[p];
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
                put_line();
        end
        drain();

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule
